@@ hw/rtl/gtfps_pkg.sv @@
// Shared types, codes and helpers for the threat field path search block.
package gtfps_pkg;

  localparam int GRID_DEF           = 8;
  localparam int FRONTIER_DEPTH_DEF = 512;

  localparam int OPC_W      = 3;
  localparam int COORD_W    = 3;
  localparam int VAL_W      = 16;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_ENEMY  = 3'd1,
    OP_FRIEND = 3'd2,
    OP_ADD    = 3'd3,
    OP_NUKE   = 3'd4,
    OP_READ   = 3'd5,
    OP_LOCAL  = 3'd6,
    OP_GLOBAL = 3'd7
  } opcode_t;

  localparam logic [KIND_W-1:0] KIND_ACK     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PATH    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_AT_GOAL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NO_PATH = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_NUKE_RANGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRE_RANGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_VALUE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COST_LIMIT  = 2'd3;

  localparam logic [3:0]  NUKE_RANGE_RST = 4'd3;
  localparam logic [3:0]  FIRE_RANGE_RST = 4'd1;
  localparam logic [14:0] MARK_VALUE_RST = 15'd100;
  localparam logic [6:0]  COST_LIMIT_RST = 7'd32;

  // Neighbor order: west, east, north, south, then the four diagonals.
  function automatic logic signed [1:0] step_dx(input logic [2:0] d);
    logic signed [1:0] r;
    unique case (d)
      3'd0: r = -2'sd1;
      3'd1: r = 2'sd1;
      3'd2: r = 2'sd0;
      3'd3: r = 2'sd0;
      3'd4: r = -2'sd1;
      3'd5: r = 2'sd1;
      3'd6: r = 2'sd1;
      3'd7: r = -2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] step_dy(input logic [2:0] d);
    logic signed [1:0] r;
    unique case (d)
      3'd0: r = 2'sd0;
      3'd1: r = 2'sd0;
      3'd2: r = -2'sd1;
      3'd3: r = 2'sd1;
      3'd4: r = -2'sd1;
      3'd5: r = 2'sd1;
      3'd6: r = -2'sd1;
      3'd7: r = 2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [VAL_W:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/gtfps_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module gtfps_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/grid_threat_field_path_search.sv @@
// Top level: threat field grid with stamps, cell access and cheapest-path search.
//
// Usage: an item is taken when start is high and busy is low; busy stays high
// until the item's last result has been registered. Results appear one per
// beat on the out_ ports, each for a single cycle with out_strobe high; the
// final beat of an item has out_last set. The receiver cannot stall.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// A stamp reads and then writes each cell of its clamped window in turn. A
// path search pops the frontier, expands each cell not yet visited, tests
// each of its neighbors, in grid or not, steps over empty cost levels, then
// walks the parent chain back from the goal and emits the path cells.
// The rate is set by the single read port of the grid memory, which every
// cell update and neighbor test goes through one access at a time.
// The frontier is three FIFO rings in one memory, one per cost modulo three.
// At reset the grid reads as all zero through per-cell valid flags, which a
// clear also drops all at once; no clearing pass is needed.
module grid_threat_field_path_search #(
  parameter int GRID           = gtfps_pkg::GRID_DEF,
  parameter int FRONTIER_DEPTH = gtfps_pkg::FRONTIER_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [gtfps_pkg::OPC_W-1:0]           in_opcode,
  input  logic [gtfps_pkg::COORD_W-1:0]         in_cell_x,
  input  logic [gtfps_pkg::COORD_W-1:0]         in_cell_y,
  input  logic signed [gtfps_pkg::VAL_W-1:0]    in_add_amount,
  output logic                                  out_strobe,
  output logic [gtfps_pkg::KIND_W-1:0]          out_kind,
  output logic [gtfps_pkg::COORD_W-1:0]         out_x,
  output logic [gtfps_pkg::COORD_W-1:0]         out_y,
  output logic signed [gtfps_pkg::VAL_W-1:0]    out_cell_value,
  output logic                                  out_last,
  input  logic                                  cfg_we,
  input  logic [gtfps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gtfps_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gtfps_pkg::*;

  localparam int CELLS = GRID * GRID;
  localparam int CW    = $clog2(GRID);
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(FRONTIER_DEPTH);
  localparam int FD    = 3 * (1 << IW);
  localparam int FAW   = $clog2(FD);
  localparam int CNT_W = $clog2(FRONTIER_DEPTH + 1);
  localparam int EW    = 4 * CW;
  localparam logic [CW-1:0]       GMAX   = CW'(GRID - 1);
  localparam logic signed [5:0]   GMAX_S = 6'(GRID - 1);
  localparam logic [IW-1:0]       IMAX   = IW'(FRONTIER_DEPTH - 1);
  localparam logic [CNT_W-1:0]    FULL   = CNT_W'(FRONTIER_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SETUP, ST_ONE_WAIT, ST_ST_RD, ST_ST_WR, ST_SV, ST_POP,
    ST_POP_WAIT, ST_CV, ST_NB, ST_NB_WAIT, ST_PATH_WR, ST_PATH_WAIT,
    ST_EMIT_RD, ST_EMIT_OUT
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y);
    return AW'(int'(y) * GRID + int'(x));
  endfunction

  function automatic logic [CW-1:0] clamp_in(input logic [COORD_W-1:0] v);
    logic [CW-1:0] r;
    if (int'(v) > GRID - 1) begin
      r = GMAX;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] clamp_s(input logic signed [5:0] v);
    logic [CW-1:0] r;
    if (v < 6'sd0) begin
      r = '0;
    end else if (v > GMAX_S) begin
      r = GMAX;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic [1:0] add3(input logic [1:0] b, input logic [1:0] k);
    logic [2:0] s;
    s = 3'(b) + 3'(k);
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] v);
    return (v == IMAX) ? '0 : v + 1'b1;
  endfunction

  state_t state_r;

  logic [3:0]  nuke_r, fire_r;
  logic [14:0] mark_r;
  logic [6:0]  glim_r;

  opcode_t op_r;
  logic [COORD_W-1:0]       xi_r, yi_r;
  logic [CW-1:0]            cx_r, cy_r;
  logic signed [VAL_W-1:0]  amt_r;

  logic [CW-1:0] wx_r, wy_r, lo_y_r, hi_x_r, hi_y_r;

  logic [CELLS-1:0] gvalid_r, visited_r;
  logic             gv_q_r;

  logic signed [VAL_W-1:0] sv_r, cv_r;
  logic [7:0]              cost_r;
  logic [1:0]              bkt_r;
  logic [2:0]              dir_r;
  logic [CW-1:0]           px_r, py_r, nx_r, ny_r, cur_x_r, cur_y_r;
  logic [IW-1:0]           head_r [3];
  logic [IW-1:0]           tail_r [3];
  logic [CNT_W-1:0]        bcnt_r [3];
  logic [CNT_W-1:0]        total_r;
  logic [AW-1:0]           n_r;

  logic                    out_strobe_r, out_last_r;
  logic [KIND_W-1:0]       out_kind_r;
  logic [COORD_W-1:0]      out_x_r, out_y_r;
  logic signed [VAL_W-1:0] out_val_r;

  // Memory ports.
  logic           g_we;
  logic [AW-1:0]  g_waddr, g_raddr;
  logic [VAL_W-1:0] g_wdata, g_rdata;
  logic           p_we;
  logic [AW-1:0]  p_waddr, p_raddr;
  logic [2*CW-1:0] p_wdata, p_rdata;
  logic           f_we;
  logic [FAW-1:0] f_waddr, f_raddr;
  logic [EW-1:0]  f_wdata, f_rdata;

  logic signed [VAL_W-1:0] g_val;
  logic [CW-1:0]           f_to_x, f_to_y;
  logic signed [CW+1:0]    nxs, nys;
  logic                    nb_in;
  logic [CW-1:0]           nb_x, nb_y;
  logic signed [5:0]       xi_s, yi_s, half_s, dwx, dwy;
  logic [3:0]              half;
  logic                    fire_zone, mark_cell;
  logic signed [VAL_W:0]   add_sum, dec_sum;
  logic                    is_goal, push_ok;
  logic [1:0]              push_bkt;

  assign g_val  = gv_q_r ? $signed(g_rdata) : '0;
  assign f_to_x = f_rdata[CW-1:0];
  assign f_to_y = f_rdata[2*CW-1:CW];

  assign nxs   = $signed({2'b00, px_r}) + step_dx(dir_r);
  assign nys   = $signed({2'b00, py_r}) + step_dy(dir_r);
  assign nb_in = (nxs >= 0) && (nxs < GRID) && (nys >= 0) && (nys < GRID);
  assign nb_x  = nxs[CW-1:0];
  assign nb_y  = nys[CW-1:0];

  assign half   = (op_r == OP_FRIEND) ? 4'd1 : nuke_r;
  assign xi_s   = $signed({3'b000, xi_r});
  assign yi_s   = $signed({3'b000, yi_r});
  assign half_s = $signed({2'b00, half});
  assign dwx    = xi_s - $signed(6'(wx_r));
  assign dwy    = yi_s - $signed(6'(wy_r));
  // The fire zone uses the distance to the unclamped center.
  assign fire_zone = ((dwx < 0) ? -dwx : dwx) <= $signed({2'b00, fire_r}) &&
                     ((dwy < 0) ? -dwy : dwy) <= $signed({2'b00, fire_r});
  assign mark_cell = (op_r != OP_ENEMY) || fire_zone;

  assign add_sum = {g_val[VAL_W-1], g_val} + {amt_r[VAL_W-1], amt_r};
  assign dec_sum = {g_val[VAL_W-1], g_val} - 17'sd1;

  assign is_goal = (sv_r > 0 && g_val <= 0) ||
                   (op_r == OP_LOCAL && g_val < 0) ||
                   (op_r == OP_GLOBAL && g_val < sv_r);

  assign push_ok  = !(cv_r <= 0 && g_val > 0) &&
                    !visited_r[cell_addr(nx_r, ny_r)] && (total_r != FULL);
  assign push_bkt = add3(bkt_r, dir_r[2] ? 2'd2 : 2'd1);

  always_comb begin
    g_raddr = cell_addr(cx_r, cy_r);
    g_we    = 1'b0;
    g_waddr = cell_addr(wx_r, wy_r);
    g_wdata = '0;
    p_we    = 1'b0;
    p_waddr = cell_addr(f_to_x, f_to_y);
    p_wdata = f_rdata[EW-1:2*CW];
    p_raddr = cell_addr(cur_x_r, cur_y_r);
    f_we    = 1'b0;
    f_waddr = {2'd0, tail_r[0]};
    f_wdata = {cy_r, cx_r, cy_r, cx_r};
    f_raddr = {bkt_r, head_r[bkt_r]};
    unique case (state_r)
      ST_ONE_WAIT: begin
        g_waddr = cell_addr(cx_r, cy_r);
        g_wdata = sat16(add_sum);
        g_we    = (op_r == OP_ADD);
      end
      ST_ST_RD: begin
        g_raddr = cell_addr(wx_r, wy_r);
      end
      ST_ST_WR: begin
        if (mark_cell) begin
          g_we    = 1'b1;
          g_wdata = {1'b0, mark_r};
        end else if (g_val <= 0) begin
          g_we    = 1'b1;
          g_wdata = sat16(dec_sum);
        end
      end
      ST_SV: begin
        f_we = 1'b1;
      end
      ST_POP_WAIT: begin
        g_raddr = cell_addr(f_to_x, f_to_y);
        p_we    = !visited_r[cell_addr(f_to_x, f_to_y)];
      end
      ST_NB: begin
        g_raddr = cell_addr(nb_x, nb_y);
      end
      ST_NB_WAIT: begin
        f_we    = push_ok;
        f_waddr = {push_bkt, tail_r[push_bkt]};
        f_wdata = {py_r, px_r, ny_r, nx_r};
      end
      ST_PATH_WR: begin
        f_we    = !(cur_x_r == cx_r && cur_y_r == cy_r);
        f_waddr = {2'd0, IW'(n_r)};
        f_wdata = EW'({cur_y_r, cur_x_r});
      end
      ST_EMIT_RD: begin
        f_raddr = {2'd0, IW'(n_r - 1'b1)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
      nuke_r       <= NUKE_RANGE_RST;
      fire_r       <= FIRE_RANGE_RST;
      mark_r       <= MARK_VALUE_RST;
      glim_r       <= COST_LIMIT_RST;
      gvalid_r     <= '0;
      visited_r    <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      gv_q_r       <= gvalid_r[g_raddr];
      if (g_we) begin
        gvalid_r[g_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUKE_RANGE: nuke_r <= cfg_data[3:0];
          CFG_FIRE_RANGE: fire_r <= cfg_data[3:0];
          CFG_MARK_VALUE: mark_r <= cfg_data;
          CFG_COST_LIMIT: glim_r <= cfg_data[6:0];
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            op_r    <= opcode_t'(in_opcode);
            xi_r    <= in_cell_x;
            yi_r    <= in_cell_y;
            cx_r    <= clamp_in(in_cell_x);
            cy_r    <= clamp_in(in_cell_y);
            amt_r   <= in_add_amount;
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          unique case (op_r)
            OP_CLEAR: begin
              gvalid_r     <= '0;
              out_strobe_r <= 1'b1;
              out_kind_r   <= KIND_ACK;
              out_x_r      <= '0;
              out_y_r      <= '0;
              out_val_r    <= '0;
              out_last_r   <= 1'b1;
              state_r      <= ST_IDLE;
            end
            OP_ADD, OP_READ: begin
              state_r <= ST_ONE_WAIT;
            end
            OP_ENEMY, OP_FRIEND, OP_NUKE: begin
              wx_r    <= clamp_s(xi_s - half_s);
              wy_r    <= clamp_s(yi_s - half_s);
              lo_y_r  <= clamp_s(yi_s - half_s);
              hi_x_r  <= clamp_s(xi_s + half_s);
              hi_y_r  <= clamp_s(yi_s + half_s);
              state_r <= ST_ST_RD;
            end
            OP_LOCAL, OP_GLOBAL: begin
              visited_r <= '0;
              for (int b = 0; b < 3; b++) begin
                head_r[b] <= '0;
                tail_r[b] <= '0;
                bcnt_r[b] <= '0;
              end
              total_r <= '0;
              cost_r  <= '0;
              bkt_r   <= 2'd0;
              state_r <= ST_SV;
            end
          endcase
        end
        ST_ONE_WAIT: begin
          out_strobe_r <= 1'b1;
          out_last_r   <= 1'b1;
          if (op_r == OP_READ) begin
            out_kind_r <= KIND_READ;
            out_x_r    <= COORD_W'(cx_r);
            out_y_r    <= COORD_W'(cy_r);
            out_val_r  <= g_val;
          end else begin
            out_kind_r <= KIND_ACK;
            out_x_r    <= '0;
            out_y_r    <= '0;
            out_val_r  <= '0;
          end
          state_r <= ST_IDLE;
        end
        ST_ST_RD: begin
          state_r <= ST_ST_WR;
        end
        ST_ST_WR: begin
          if (wy_r == hi_y_r) begin
            wy_r <= lo_y_r;
            if (wx_r == hi_x_r) begin
              out_strobe_r <= 1'b1;
              out_kind_r   <= KIND_ACK;
              out_x_r      <= '0;
              out_y_r      <= '0;
              out_val_r    <= '0;
              out_last_r   <= 1'b1;
              state_r      <= ST_IDLE;
            end else begin
              wx_r    <= wx_r + 1'b1;
              state_r <= ST_ST_RD;
            end
          end else begin
            wy_r    <= wy_r + 1'b1;
            state_r <= ST_ST_RD;
          end
        end
        ST_SV: begin
          // The start cell goes in at cost zero.
          sv_r      <= g_val;
          tail_r[0] <= ring_inc(tail_r[0]);
          bcnt_r[0] <= bcnt_r[0] + 1'b1;
          total_r   <= total_r + 1'b1;
          state_r   <= ST_POP;
        end
        ST_POP: begin
          if (bcnt_r[bkt_r] == '0) begin
            if (total_r == '0) begin
              out_strobe_r <= 1'b1;
              out_kind_r   <= KIND_NO_PATH;
              out_x_r      <= '0;
              out_y_r      <= '0;
              out_val_r    <= '0;
              out_last_r   <= 1'b1;
              state_r      <= ST_IDLE;
            end else begin
              bkt_r  <= add3(bkt_r, 2'd1);
              cost_r <= cost_r + 1'b1;
            end
          end else begin
            head_r[bkt_r] <= ring_inc(head_r[bkt_r]);
            bcnt_r[bkt_r] <= bcnt_r[bkt_r] - 1'b1;
            total_r       <= total_r - 1'b1;
            state_r       <= ST_POP_WAIT;
          end
        end
        ST_POP_WAIT: begin
          if (visited_r[cell_addr(f_to_x, f_to_y)]) begin
            state_r <= ST_POP;
          end else begin
            visited_r[cell_addr(f_to_x, f_to_y)] <= 1'b1;
            px_r    <= f_to_x;
            py_r    <= f_to_y;
            state_r <= ST_CV;
          end
        end
        ST_CV: begin
          cv_r  <= g_val;
          dir_r <= 3'd0;
          if (is_goal) begin
            if (px_r == cx_r && py_r == cy_r) begin
              out_strobe_r <= 1'b1;
              out_kind_r   <= KIND_AT_GOAL;
              out_x_r      <= '0;
              out_y_r      <= '0;
              out_val_r    <= '0;
              out_last_r   <= 1'b1;
              state_r      <= ST_IDLE;
            end else begin
              cur_x_r <= px_r;
              cur_y_r <= py_r;
              n_r     <= '0;
              state_r <= ST_PATH_WR;
            end
          end else if (op_r == OP_GLOBAL && cost_r > {1'b0, glim_r}) begin
            out_strobe_r <= 1'b1;
            out_kind_r   <= KIND_NO_PATH;
            out_x_r      <= '0;
            out_y_r      <= '0;
            out_val_r    <= '0;
            out_last_r   <= 1'b1;
            state_r      <= ST_IDLE;
          end else begin
            state_r <= ST_NB;
          end
        end
        ST_NB: begin
          if (nb_in) begin
            nx_r    <= nb_x;
            ny_r    <= nb_y;
            state_r <= ST_NB_WAIT;
          end else if (dir_r == 3'd7) begin
            state_r <= ST_POP;
          end else begin
            dir_r <= dir_r + 1'b1;
          end
        end
        ST_NB_WAIT: begin
          if (push_ok) begin
            tail_r[push_bkt] <= ring_inc(tail_r[push_bkt]);
            bcnt_r[push_bkt] <= bcnt_r[push_bkt] + 1'b1;
            total_r          <= total_r + 1'b1;
          end
          dir_r   <= dir_r + 1'b1;
          state_r <= (dir_r == 3'd7) ? ST_POP : ST_NB;
        end
        ST_PATH_WR: begin
          // Walk back from the goal, stacking cells until the start is reached.
          if (cur_x_r == cx_r && cur_y_r == cy_r) begin
            state_r <= ST_EMIT_RD;
          end else begin
            n_r     <= n_r + 1'b1;
            state_r <= ST_PATH_WAIT;
          end
        end
        ST_PATH_WAIT: begin
          cur_x_r <= p_rdata[CW-1:0];
          cur_y_r <= p_rdata[2*CW-1:CW];
          state_r <= ST_PATH_WR;
        end
        ST_EMIT_RD: begin
          n_r     <= n_r - 1'b1;
          state_r <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          out_strobe_r <= 1'b1;
          out_kind_r   <= KIND_PATH;
          out_x_r      <= COORD_W'(f_rdata[CW-1:0]);
          out_y_r      <= COORD_W'(f_rdata[2*CW-1:CW]);
          out_val_r    <= '0;
          out_last_r   <= (n_r == '0);
          state_r      <= (n_r == '0) ? ST_IDLE : ST_EMIT_RD;
        end
      endcase
    end
  end

  gtfps_ram #(.W(VAL_W), .D(CELLS)) u_grid_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  gtfps_ram #(.W(2 * CW), .D(CELLS)) u_parent_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  gtfps_ram #(.W(EW), .D(FD)) u_front_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  assign busy           = (state_r != ST_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_kind       = out_kind_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_cell_value = out_val_r;
  assign out_last       = out_last_r;

endmodule

@@ hw/rtl/gtfps_chk.sv @@
// Port-level checker for the threat field path search block, with its bind.
module gtfps_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_strobe,
  input logic [gtfps_pkg::KIND_W-1:0]        out_kind,
  input logic signed [gtfps_pkg::VAL_W-1:0]  out_cell_value,
  input logic                                out_last
);
  import gtfps_pkg::*;

  // A beat that is not the last one belongs to an item still in progress.
  a_mid_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy)
    else $error("non-final result beat while idle");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // Only path cells come as a train of several beats.
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind != KIND_PATH |-> out_last)
    else $error("single-beat result without last");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind != KIND_READ |-> out_cell_value == '0)
    else $error("cell value set on a result other than a read");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !out_strobe)
    else $error("result beat right after a final beat");

endmodule

bind grid_threat_field_path_search gtfps_chk u_gtfps_chk (.*);
